// ----- sv/pts_pkg.sv -----
// Shared types and codes of the priority task scheduler.
`default_nettype none
package pts_pkg;

    localparam int unsigned PRIO_W = 8;
    localparam int unsigned TIME_W = 32;

    typedef enum logic [2:0] {
        ACT_CREATE   = 3'd0,
        ACT_SCHEDULE = 3'd1,
        ACT_DONE     = 3'd2,
        ACT_SLEEP    = 3'd3,
        ACT_SEM_WAIT = 3'd4,
        ACT_SEM_POST = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        TS_READY    = 2'd0,
        TS_RUNNING  = 2'd1,
        TS_SLEEPING = 2'd2,
        TS_BLOCKED  = 2'd3
    } task_state_t;

    typedef enum logic [1:0] {
        RS_OK         = 2'd0,
        RS_FULL       = 2'd1,
        RS_NO_READY   = 2'd2,
        RS_NO_CURRENT = 2'd3
    } result_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_PICK,
        S_RESP
    } seq_state_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        logic [2:0]        action;
        logic [PRIO_W-1:0] priority_req;
        logic [TIME_W-1:0] sleep_ticks;
        logic [TIME_W-1:0] now_time;
        logic [1:0]        sem_index;
    } req_t;

    typedef struct packed {
        result_status_t status;
        logic [2:0]     task_id;
        logic           granted;
    } rsp_t;

    typedef struct packed {
        logic              we_prio;
        logic              we_status;
        logic              we_wake;
        logic [PRIO_W-1:0] prio;
        task_state_t       status;
        logic [TIME_W-1:0] wake;
    } tbl_wr_t;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        task_state_t       status;
        logic [TIME_W-1:0] wake;
    } tbl_rd_t;

endpackage
`default_nettype wire

// ----- sv/pts_alu.sv -----
// Shared 32-bit adder/subtractor: wake-time sums and wake-time compares.
`default_nettype none
module pts_alu (
    input  pts_pkg::alu_op_t              op,
    input  logic [pts_pkg::TIME_W-1:0]    a,
    input  logic [pts_pkg::TIME_W-1:0]    b,
    output logic [pts_pkg::TIME_W-1:0]    sum,
    output logic                          carry
);
    import pts_pkg::*;

    logic [TIME_W-1:0] b_eff;
    logic              cin;

    always_comb begin
        b_eff = (op == ALU_SUB) ? ~b : b;
        cin   = (op == ALU_SUB);
    end

    // On subtract, carry out set means a >= b
    assign {carry, sum} = (TIME_W + 1)'(a) + (TIME_W + 1)'(b_eff) + (TIME_W + 1)'(cin);

endmodule
`default_nettype wire

// ----- sv/pts_table.sv -----
// Task table: priority, state and wake time per slot, one read and one write port.
`default_nettype none
module pts_table #(
    parameter int unsigned DEPTH  = 8,
    parameter int unsigned ADDR_W = 3
) (
    input  logic                aclk,
    input  logic [ADDR_W-1:0]   rd_addr,
    output pts_pkg::tbl_rd_t    rd,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  pts_pkg::tbl_wr_t    wr
);
    import pts_pkg::*;

    logic [PRIO_W-1:0] prio_reg [DEPTH];
    task_state_t       stat_reg [DEPTH];
    logic [TIME_W-1:0] wake_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr.we_prio) begin
            prio_reg[wr_addr] <= wr.prio;
        end
        if (wr.we_status) begin
            stat_reg[wr_addr] <= wr.status;
        end
        if (wr.we_wake) begin
            wake_reg[wr_addr] <= wr.wake;
        end
    end

    always_comb begin
        rd.prio   = prio_reg[rd_addr];
        rd.status = stat_reg[rd_addr];
        rd.wake   = wake_reg[rd_addr];
    end

endmodule
`default_nettype wire

// ----- sv/pts_seq.sv -----
// Request sequencer: decodes a request, scans the task table slot by slot, keeps
// the running task and semaphore state.
`default_nettype none
module pts_seq #(
    parameter int unsigned MAX_TASK_SLOTS = 8,
    parameter int unsigned NUM_SEMAPHORES = 4,
    parameter int unsigned TID_W          = 3,
    parameter int unsigned CNT_W          = 4
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    input  pts_pkg::req_t              in_req,
    output logic                       in_ready,
    input  logic                       out_free,
    output logic                       rsp_valid,
    output pts_pkg::rsp_t              rsp,
    output logic [TID_W-1:0]           rd_addr,
    input  pts_pkg::tbl_rd_t           rd,
    output logic [TID_W-1:0]           wr_addr,
    output pts_pkg::tbl_wr_t           wr,
    output pts_pkg::alu_op_t           alu_op,
    output logic [pts_pkg::TIME_W-1:0] alu_a,
    output logic [pts_pkg::TIME_W-1:0] alu_b,
    input  logic [pts_pkg::TIME_W-1:0] alu_sum,
    input  logic                       alu_carry
);
    import pts_pkg::*;

    localparam int unsigned SEM_W  = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
    localparam int unsigned SEL_W  = (SEM_W > 2) ? SEM_W : 2;
    localparam int unsigned IDX_XW = (TID_W > 3) ? TID_W : 3;
    localparam int unsigned SCMP_W = 5;

    seq_state_t state_reg, state_next;
    req_t       req_reg;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [TID_W-1:0]  run_task_reg, run_task_next;
    logic              run_valid_reg, run_valid_next;
    logic [NUM_SEMAPHORES-1:0] sem_free_reg, sem_free_next;
    logic [NUM_SEMAPHORES-1:0] sem_wv_reg, sem_wv_next;
    logic [TID_W-1:0]  sem_waiter_reg [NUM_SEMAPHORES];
    logic [TID_W-1:0]  sem_waiter_next [NUM_SEMAPHORES];

    logic [TID_W-1:0]  idx_reg, idx_next;
    logic [TID_W-1:0]  best_reg, best_next;
    logic [PRIO_W-1:0] best_prio_reg, best_prio_next;
    logic              found_reg, found_next;
    rsp_t              rsp_reg, rsp_next;

    logic [SEL_W-1:0]  sem_ext;
    logic [SEM_W-1:0]  sem_sel;
    logic              sem_ok;
    logic              scan_last;
    logic              woke;
    logic              slot_ready;

    always_comb begin
        sem_ext   = SEL_W'(req_reg.sem_index);
        sem_sel   = sem_ext[SEM_W-1:0];
        sem_ok    = SCMP_W'(req_reg.sem_index) < SCMP_W'(NUM_SEMAPHORES);
        scan_last = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;
    end

    function automatic logic [2:0] to_id(input logic [TID_W-1:0] slot);
        logic [IDX_XW-1:0] ext;
        ext = IDX_XW'(slot);
        return ext[2:0];
    endfunction

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (req_reg.action == ACT_SCHEDULE && count_reg != '0) begin
                    state_next = S_SCAN;
                end else begin
                    state_next = S_RESP;
                end
            end
            S_SCAN: begin
                if (scan_last) begin
                    state_next = S_PICK;
                end
            end
            S_PICK: begin
                state_next = S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs and datapath updates
    always_comb begin
        in_ready        = 1'b0;
        rsp_valid       = 1'b0;
        rd_addr         = run_task_reg;
        wr_addr         = run_task_reg;
        wr              = '0;
        wr.status       = TS_READY;
        wr.prio         = req_reg.priority_req;
        wr.wake         = alu_sum;
        alu_op          = ALU_ADD;
        alu_a           = req_reg.now_time;
        alu_b           = req_reg.sleep_ticks;
        woke            = 1'b0;
        slot_ready      = 1'b0;
        count_next      = count_reg;
        run_task_next   = run_task_reg;
        run_valid_next  = run_valid_reg;
        sem_free_next   = sem_free_reg;
        sem_wv_next     = sem_wv_reg;
        sem_waiter_next = sem_waiter_reg;
        idx_next        = idx_reg;
        best_next       = best_reg;
        best_prio_next  = best_prio_reg;
        found_next      = found_reg;
        rsp_next        = rsp_reg;

        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
            end
            S_EXEC: begin
                rsp_next.status  = RS_OK;
                rsp_next.task_id = 3'd0;
                rsp_next.granted = 1'b0;
                case (req_reg.action)
                    ACT_CREATE: begin
                        if (count_reg >= CNT_W'(MAX_TASK_SLOTS)) begin
                            rsp_next.status = RS_FULL;
                        end else begin
                            wr_addr          = count_reg[TID_W-1:0];
                            wr.we_prio       = 1'b1;
                            wr.we_status     = 1'b1;
                            wr.status        = TS_READY;
                            rsp_next.task_id = to_id(count_reg[TID_W-1:0]);
                            count_next       = count_reg + CNT_W'(1);
                        end
                    end
                    ACT_SCHEDULE: begin
                        idx_next   = '0;
                        found_next = 1'b0;
                        if (count_reg == '0) begin
                            rsp_next.status = RS_NO_READY;
                        end
                    end
                    ACT_DONE: begin
                        if (!run_valid_reg) begin
                            rsp_next.status = RS_NO_CURRENT;
                        end else if (rd.status == TS_RUNNING) begin
                            wr.we_status = 1'b1;
                            wr.status    = TS_READY;
                        end
                    end
                    ACT_SLEEP: begin
                        if (!run_valid_reg) begin
                            rsp_next.status = RS_NO_CURRENT;
                        end else begin
                            wr.we_status = 1'b1;
                            wr.we_wake   = 1'b1;
                            wr.status    = TS_SLEEPING;
                        end
                    end
                    ACT_SEM_WAIT: begin
                        if (sem_ok) begin
                            if (sem_free_reg[sem_sel]) begin
                                sem_free_next[sem_sel] = 1'b0;
                                rsp_next.granted       = 1'b1;
                            end else if (!run_valid_reg) begin
                                rsp_next.status = RS_NO_CURRENT;
                            end else begin
                                wr.we_status             = 1'b1;
                                wr.status                = TS_BLOCKED;
                                sem_waiter_next[sem_sel] = run_task_reg;
                                sem_wv_next[sem_sel]     = 1'b1;
                            end
                        end
                    end
                    ACT_SEM_POST: begin
                        if (sem_ok) begin
                            sem_free_next[sem_sel] = 1'b1;
                            if (sem_wv_reg[sem_sel]) begin
                                wr_addr              = sem_waiter_reg[sem_sel];
                                wr.we_status         = 1'b1;
                                wr.status            = TS_READY;
                                sem_wv_next[sem_sel] = 1'b0;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_SCAN: begin
                // Wake a due sleeper, then keep the best ready slot so far
                rd_addr    = idx_reg;
                wr_addr    = idx_reg;
                alu_op     = ALU_SUB;
                alu_b      = rd.wake;
                woke       = (rd.status == TS_SLEEPING) && alu_carry;
                slot_ready = (rd.status == TS_READY) || woke;
                if (woke) begin
                    wr.we_status = 1'b1;
                    wr.status    = TS_READY;
                end
                if (slot_ready && (!found_reg || rd.prio > best_prio_reg)) begin
                    best_next      = idx_reg;
                    best_prio_next = rd.prio;
                    found_next     = 1'b1;
                end
                idx_next = idx_reg + TID_W'(1);
            end
            S_PICK: begin
                wr_addr = best_reg;
                if (found_reg) begin
                    wr.we_status     = 1'b1;
                    wr.status        = TS_RUNNING;
                    run_task_next    = best_reg;
                    run_valid_next   = 1'b1;
                    rsp_next.task_id = to_id(best_reg);
                end else begin
                    rsp_next.status = RS_NO_READY;
                end
            end
            S_RESP: begin
                rsp_valid = out_free;
            end
            default: begin
            end
        endcase
    end

    assign rsp = rsp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            run_task_reg   <= '0;
            run_valid_reg  <= 1'b0;
            sem_free_reg   <= '1;
            sem_wv_reg     <= '0;
            for (int i = 0; i < int'(NUM_SEMAPHORES); i++) begin
                sem_waiter_reg[i] <= '0;
            end
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            run_task_reg   <= run_task_next;
            run_valid_reg  <= run_valid_next;
            sem_free_reg   <= sem_free_next;
            sem_wv_reg     <= sem_wv_next;
            sem_waiter_reg <= sem_waiter_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            req_reg <= in_req;
        end
        idx_reg       <= idx_next;
        best_reg      <= best_next;
        best_prio_reg <= best_prio_next;
        found_reg     <= found_next;
        rsp_reg       <= rsp_next;
    end

endmodule
`default_nettype wire

// ----- sv/priority_task_scheduler_unit.sv -----
// Top level of the priority task scheduler: request/result stream ports and output register.
// Takes one request at a time and answers each with exactly one result. Create,
// done, sleep, semaphore wait and semaphore post are decoded and carried out in
// the execute state, then go straight to the response state. Schedule walks the
// task table one slot per cycle through the single table read port and one
// shared 32-bit adder that checks each sleeper's wake time, then commits the
// pick in a separate step; with an empty table it answers without a scan.
// The result sits in an output register, so the next request is taken while it
// waits; the sequencer only stalls at its last step if that register is still
// full. No clearing pass runs after reset.
`default_nettype none
module priority_task_scheduler_unit #(
    parameter int unsigned MAX_TASK_SLOTS = 8,
    parameter int unsigned NUM_SEMAPHORES = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // priority_req[7:0], sleep_ticks[39:8], now_time[71:40],
                                   // sem_index[73:72], zero[79:74]
    input  logic [2:0]  s_tuser,   // action[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // status[1:0], task_id[4:2], granted[5], zero[7:6]
);
    import pts_pkg::*;

    localparam int unsigned TID_W = (MAX_TASK_SLOTS > 1) ? $clog2(MAX_TASK_SLOTS) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_TASK_SLOTS + 1);

    req_t              in_req;
    rsp_t              rsp;
    logic              rsp_valid;
    logic              out_free;
    logic [TID_W-1:0]  rd_addr;
    logic [TID_W-1:0]  wr_addr;
    tbl_rd_t           tbl_rd;
    tbl_wr_t           tbl_wr;
    alu_op_t           alu_op;
    logic [TIME_W-1:0] alu_a;
    logic [TIME_W-1:0] alu_b;
    logic [TIME_W-1:0] alu_sum;
    logic              alu_carry;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [7:0]        m_tdata_reg, m_tdata_next;

    always_comb begin
        in_req.action       = s_tuser;
        in_req.priority_req = s_tdata[7:0];
        in_req.sleep_ticks  = s_tdata[39:8];
        in_req.now_time     = s_tdata[71:40];
        in_req.sem_index    = s_tdata[73:72];
    end

    assign out_free = !m_tvalid_reg || m_tready;

    pts_seq #(
        .MAX_TASK_SLOTS (MAX_TASK_SLOTS),
        .NUM_SEMAPHORES (NUM_SEMAPHORES),
        .TID_W          (TID_W),
        .CNT_W          (CNT_W)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_req    (in_req),
        .in_ready  (s_tready),
        .out_free  (out_free),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .rd_addr   (rd_addr),
        .rd        (tbl_rd),
        .wr_addr   (wr_addr),
        .wr        (tbl_wr),
        .alu_op    (alu_op),
        .alu_a     (alu_a),
        .alu_b     (alu_b),
        .alu_sum   (alu_sum),
        .alu_carry (alu_carry)
    );

    pts_table #(
        .DEPTH  (MAX_TASK_SLOTS),
        .ADDR_W (TID_W)
    ) u_table (
        .aclk    (aclk),
        .rd_addr (rd_addr),
        .rd      (tbl_rd),
        .wr_addr (wr_addr),
        .wr      (tbl_wr)
    );

    pts_alu u_alu (
        .op    (alu_op),
        .a     (alu_a),
        .b     (alu_b),
        .sum   (alu_sum),
        .carry (alu_carry)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (rsp_valid) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {2'b00, rsp.granted, rsp.task_id, rsp.status};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // One request in flight at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while another is in flight");

    // A result is only loaded when the output register can take it
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp_valid |-> (!m_tvalid_reg || m_tready))
        else $error("result overwrote an undelivered result");

    // A granted semaphore always reports ok
    a_grant_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[5] |-> m_tdata[1:0] == RS_OK)
        else $error("granted result with error status");

endmodule
`default_nettype wire

// ----- dv/priority_task_scheduler_checker.sv -----
// Checker for the priority task scheduler: predicts every result and compares it field by field.
`timescale 1ns / 1ps
module priority_task_scheduler_checker #(
    parameter int unsigned MAX_TASK_SLOTS = 8,
    parameter int unsigned NUM_SEMAPHORES = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [79:0] s_tdata,   // priority_req[7:0], sleep_ticks[39:8], now_time[71:40],
                                   // sem_index[73:72], zero[79:74]
    input  logic [2:0]  s_tuser,   // action[2:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // status[1:0], task_id[4:2], granted[5], zero[7:6]
    output int unsigned error_count,
    output int unsigned pending_count
);
    import pts_pkg::*;

    // shadow of the task table and semaphores
    logic [3:0]  slot_count;
    logic [7:0]  slot_prio [MAX_TASK_SLOTS];
    task_state_t slot_state [MAX_TASK_SLOTS];
    logic [31:0] slot_wake [MAX_TASK_SLOTS];
    logic [2:0]  cur_slot;
    logic        cur_valid;
    logic        sem_avail [NUM_SEMAPHORES];
    logic [2:0]  sem_waiter_slot [NUM_SEMAPHORES];
    logic        sem_waiter_valid [NUM_SEMAPHORES];

    rsp_t scheduler_answers [$];

    initial begin
        error_count = 0;
        pending_count = 0;
    end

    task automatic report_mismatch(input string what, input int unsigned exp_val,
                                   input int unsigned got_val);
        $display("%0t ns checker: %s expected %0d got %0d", $time, what, exp_val, got_val);
        error_count++;
    endtask

    // Apply one request to the shadow state and return the answer it earns.
    function automatic rsp_t resolve_request(input logic [2:0] act, input logic [7:0] prio,
                                             input logic [31:0] ticks,
                                             input logic [31:0] now, input logic [1:0] sem);
        rsp_t       r;
        logic       found;
        logic [2:0] best;
        int         i;
        r.status  = RS_OK;
        r.task_id = 3'd0;
        r.granted = 1'b0;
        found = 1'b0;
        best  = 3'd0;
        case (act)
            ACT_CREATE: begin
                if (slot_count >= MAX_TASK_SLOTS) begin
                    r.status = RS_FULL;
                end else begin
                    slot_prio[slot_count]  = prio;
                    slot_state[slot_count] = TS_READY;
                    r.task_id  = slot_count[2:0];
                    slot_count = slot_count + 4'd1;
                end
            end
            ACT_SCHEDULE: begin
                for (i = 0; i < MAX_TASK_SLOTS; i++) begin
                    if (i < slot_count) begin
                        // wake due sleepers before picking
                        if (slot_state[i] == TS_SLEEPING && slot_wake[i] <= now)
                            slot_state[i] = TS_READY;
                        if (slot_state[i] == TS_READY && (!found || slot_prio[i] > slot_prio[best])) begin
                            best  = i[2:0];
                            found = 1'b1;
                        end
                    end
                end
                if (found) begin
                    slot_state[best] = TS_RUNNING;
                    cur_slot  = best;
                    cur_valid = 1'b1;
                    r.task_id = best;
                end else begin
                    r.status = RS_NO_READY;
                end
            end
            ACT_DONE: begin
                if (!cur_valid)
                    r.status = RS_NO_CURRENT;
                else if (slot_state[cur_slot] == TS_RUNNING)
                    slot_state[cur_slot] = TS_READY;
            end
            ACT_SLEEP: begin
                if (!cur_valid) begin
                    r.status = RS_NO_CURRENT;
                end else begin
                    slot_state[cur_slot] = TS_SLEEPING;
                    slot_wake[cur_slot]  = now + ticks;
                end
            end
            ACT_SEM_WAIT: begin
                if (sem < NUM_SEMAPHORES) begin
                    if (sem_avail[sem]) begin
                        sem_avail[sem] = 1'b0;
                        r.granted = 1'b1;
                    end else if (!cur_valid) begin
                        r.status = RS_NO_CURRENT;
                    end else begin
                        // a later waiter replaces the recorded one
                        slot_state[cur_slot]  = TS_BLOCKED;
                        sem_waiter_slot[sem]  = cur_slot;
                        sem_waiter_valid[sem] = 1'b1;
                    end
                end
            end
            ACT_SEM_POST: begin
                if (sem < NUM_SEMAPHORES) begin
                    sem_avail[sem] = 1'b1;
                    if (sem_waiter_valid[sem]) begin
                        slot_state[sem_waiter_slot[sem]] = TS_READY;
                        sem_waiter_valid[sem] = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        rsp_t exp_rsp;
        if (!aresetn) begin
            slot_count = 4'd0;
            cur_slot   = 3'd0;
            cur_valid  = 1'b0;
            for (int i = 0; i < MAX_TASK_SLOTS; i++) begin
                slot_prio[i]  = 8'd0;
                slot_state[i] = TS_READY;
                slot_wake[i]  = 32'd0;
            end
            for (int j = 0; j < NUM_SEMAPHORES; j++) begin
                sem_avail[j]        = 1'b1;
                sem_waiter_slot[j]  = 3'd0;
                sem_waiter_valid[j] = 1'b0;
            end
            scheduler_answers.delete();
        end else begin
            // retire the oldest answer before adding the new request
            if (m_tvalid && m_tready) begin
                if (scheduler_answers.size() == 0) begin
                    report_mismatch("result with no request outstanding", 0, m_tdata);
                end else begin
                    exp_rsp = scheduler_answers.pop_front();
                    if (m_tdata[1:0] != exp_rsp.status)
                        report_mismatch("status", exp_rsp.status, m_tdata[1:0]);
                    if (m_tdata[4:2] != exp_rsp.task_id)
                        report_mismatch("task_id", exp_rsp.task_id, m_tdata[4:2]);
                    if (m_tdata[5] != exp_rsp.granted)
                        report_mismatch("granted", exp_rsp.granted, m_tdata[5]);
                end
            end
            if (s_tvalid && s_tready)
                scheduler_answers.push_back(resolve_request(s_tuser, s_tdata[7:0],
                                                            s_tdata[39:8], s_tdata[71:40],
                                                            s_tdata[73:72]));
        end
        pending_count = scheduler_answers.size();
    end

endmodule

// ----- dv/priority_task_scheduler_unit_tb.sv -----
// Testbench top for the priority task scheduler: clock, reset, request and result traffic, verdict.
`timescale 1ns / 1ps
module priority_task_scheduler_unit_tb;
    import pts_pkg::*;

    // action codes the block decodes as no-ops
    localparam logic [2:0] ACT_SPARE_LO = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;
    localparam int unsigned RANDOM_REQUESTS = 900;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;   // priority_req[7:0], sleep_ticks[39:8], now_time[71:40],
                            // sem_index[73:72], zero[79:74]
    logic [2:0]  s_tuser;   // action[2:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // status[1:0], task_id[4:2], granted[5], zero[7:6]

    int unsigned error_count;
    int unsigned pending_count;
    bit          quiet;

    priority_task_scheduler_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    priority_task_scheduler_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("priority_task_scheduler_unit_tb: FAIL");
        $finish;
    end

    // Hold one request until accepted; leaves the caller at the accepting edge.
    task automatic send_request(input logic [2:0] act, input logic [7:0] prio,
                                input logic [31:0] ticks, input logic [31:0] now,
                                input logic [1:0] sem);
        int unsigned gap;
        gap = quiet ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {6'd0, sem, now, ticks, prio};
        do @(posedge aclk); while (!s_tready);
    endtask

    // result side backpressure
    initial begin
        int unsigned stall;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 15);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin
        int unsigned sent;
        int unsigned sem_pick;
        int unsigned pattern;
        int unsigned guard;
        logic [2:0]  act;
        logic [31:0] tick_now;
        quiet    = 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= 3'd0;
        s_tdata  <= 80'd0;
        aresetn  <= 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // empty table: nothing to schedule, no current task
        send_request(ACT_SCHEDULE, 8'd0, 32'd0, 32'd0, 2'd0);
        send_request(ACT_DONE, 8'd0, 32'd0, 32'd0, 2'd0);
        send_request(ACT_SLEEP, 8'd0, 32'd5, 32'd0, 2'd0);
        // free semaphore is granted with no current task, then refused
        send_request(ACT_SEM_WAIT, 8'd0, 32'd0, 32'd0, 2'd0);
        send_request(ACT_SEM_WAIT, 8'd0, 32'd0, 32'd0, 2'd0);
        send_request(ACT_SPARE_LO, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3);
        send_request(ACT_SPARE_HI, 8'd0, 32'd0, 32'd0, 2'd0);
        // fill the table, with a tie at the top priority, then overflow it
        send_request(ACT_CREATE, 8'd0, 32'd0, 32'd0, 2'd0);
        send_request(ACT_CREATE, 8'd255, 32'd0, 32'd0, 2'd0);
        send_request(ACT_CREATE, 8'd255, 32'd0, 32'd0, 2'd0);
        send_request(ACT_CREATE, 8'd17, 32'd0, 32'd0, 2'd0);
        send_request(ACT_CREATE, 8'd128, 32'd0, 32'd0, 2'd0);
        send_request(ACT_CREATE, 8'd200, 32'd0, 32'd0, 2'd0);
        send_request(ACT_CREATE, 8'd1, 32'd0, 32'd0, 2'd0);
        send_request(ACT_CREATE, 8'd254, 32'd0, 32'd0, 2'd0);
        send_request(ACT_CREATE, 8'd99, 32'd0, 32'd0, 2'd0);
        // second schedule while the first pick still runs
        send_request(ACT_SCHEDULE, 8'd0, 32'd0, 32'd0, 2'd0);
        send_request(ACT_SCHEDULE, 8'd0, 32'd0, 32'd0, 2'd0);
        send_request(ACT_DONE, 8'd0, 32'd0, 32'd0, 2'd0);
        // wake time wraps; done on a sleeping current task changes nothing
        send_request(ACT_SLEEP, 8'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd0);
        send_request(ACT_DONE, 8'd0, 32'd0, 32'd0, 2'd0);
        send_request(ACT_SCHEDULE, 8'd0, 32'd0, 32'd0, 2'd0);
        // take the free semaphore, block, replace the waiter, then post to the last one
        send_request(ACT_SEM_WAIT, 8'd0, 32'd0, 32'd0, 2'd3);
        send_request(ACT_SEM_WAIT, 8'd0, 32'd0, 32'd0, 2'd3);
        send_request(ACT_SCHEDULE, 8'd0, 32'd0, 32'd10, 2'd0);
        send_request(ACT_SEM_WAIT, 8'd0, 32'd0, 32'd10, 2'd3);
        send_request(ACT_SEM_POST, 8'd0, 32'd0, 32'd10, 2'd3);
        // wake the wrapped sleeper at the top of time
        send_request(ACT_SCHEDULE, 8'd0, 32'd0, 32'hFFFF_FFFF, 2'd0);
        send_request(ACT_DONE, 8'd0, 32'd0, 32'd0, 2'd0);

        // mostly well-formed slices: schedule, optional semaphore use, then yield
        sent = 0;
        tick_now = 32'd100;
        while (sent < RANDOM_REQUESTS) begin
            quiet = ((sent / 120) % 3) == 1;
            tick_now = tick_now + $urandom_range(0, 8);
            if ($urandom_range(0, 9) == 0) begin
                act = 3'($urandom_range(0, 7));
                send_request(act, 8'($urandom), $urandom,
                             ($urandom_range(0, 3) == 0) ? $urandom : tick_now,
                             2'($urandom_range(0, 3)));
                if (act <= ACT_SEM_POST)
                    sent++;
            end else begin
                send_request(ACT_SCHEDULE, 8'($urandom), $urandom, tick_now,
                             2'($urandom_range(0, 3)));
                sent++;
                if ($urandom_range(0, 1) == 1) begin
                    sem_pick = $urandom_range(0, 3);
                    pattern  = $urandom_range(0, 2);
                    if (pattern != 0)
                        send_request(ACT_SEM_WAIT, 8'($urandom), $urandom, tick_now,
                                     2'(sem_pick));
                    if (pattern == 2)
                        send_request(ACT_SEM_WAIT, 8'($urandom), $urandom, tick_now,
                                     2'(sem_pick));
                    // release so no waiter outlives the slice
                    send_request(ACT_SEM_POST, 8'($urandom), $urandom, tick_now,
                                 2'(sem_pick));
                    sent += pattern + 1;
                end
                if ($urandom_range(0, 4) < 3)
                    send_request(ACT_DONE, 8'($urandom), $urandom, tick_now,
                                 2'($urandom_range(0, 3)));
                else
                    send_request(ACT_SLEEP, 8'($urandom),
                                 ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 30),
                                 tick_now, 2'($urandom_range(0, 3)));
                sent++;
            end
        end
        s_tvalid <= 1'b0;
        quiet = 1'b0;

        guard = 0;
        while (pending_count != 0 && guard < 4000) begin
            @(negedge aclk);
            guard++;
        end
        if (pending_count != 0) begin
            $display("priority_task_scheduler_unit_tb: FAIL");
            $finish;
        end else begin
            repeat (20) @(posedge aclk);
            @(negedge aclk);
            if (error_count == 0 && pending_count == 0)
                $display("priority_task_scheduler_unit_tb: PASS");
            else
                $display("priority_task_scheduler_unit_tb: FAIL");
            $finish;
        end
    end

endmodule

// ----- priority_task_scheduler_unit.f -----
sv/pts_pkg.sv
sv/pts_alu.sv
sv/pts_table.sv
sv/pts_seq.sv
sv/priority_task_scheduler_unit.sv
dv/priority_task_scheduler_checker.sv
dv/priority_task_scheduler_unit_tb.sv
